// File: rtl/unicode_transcoder_macros.svh
// Assertion macros shared by the transcoder RTL.
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
`ifndef UNICODE_TRANSCODER_MACROS_SVH
`define UNICODE_TRANSCODER_MACROS_SVH
`ifndef SYNTHESIS
`define UT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define UT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define UT_ASSERT(lbl, prop, msg)
`define UT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/ut_pkg.sv
// Shared types and constants of the Unicode transcoder.
// No dependencies; used by every module of the block.
`default_nettype none
package ut_pkg;

	localparam logic [1:0] ENC_BYTE  = 2'd0;
	localparam logic [1:0] ENC_UTF8  = 2'd1;
	localparam logic [1:0] ENC_UTF16 = 2'd2;
	localparam logic [1:0] ENC_UTF32 = 2'd3;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 2'd1;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [31:0] in_unit;
		logic        text_end;
	} ut_src_t;

	typedef struct packed {
		logic [31:0] out_unit;
		logic        run_last;
		logic        text_last;
	} ut_dst_t;

	// One complete code point, or a unit to be copied unchanged.
	typedef struct packed {
		logic [31:0] code;
		logic        copy;
		logic        text_end;
	} ut_entry_t;

endpackage
`default_nettype wire

// File: rtl/unicode_transcoder.sv
// Top level of the Unicode transcoder: configuration registers and the
// front end, queue and back end. Depends on ut_pkg, ut_front, ut_queue, ut_back.
//
//   channel | direction | word                   | handshake
//   src     | in        | in_unit, text_end      | src_valid / src_ready
//   dst     | out       | out_unit, run_last,    | dst_valid / dst_ready
//           |           | text_last              |
//   cfg     | in        | cfg_index, cfg_data    | cfg_valid / cfg_ready
//
// A source word is decoded in the cycle it is accepted and a complete code point
// enters a two-entry queue; the back end sends one target word per cycle while dst
// is not stalled, and an item yields one to four target words.
// With the queue empty, a word is written into the queue and then into the output register before it is offered.
// Reset clears both encodings to single-byte and drops any pending sequence.
// src stalls only while the queue is full; dst back-pressure fills the queue.
`default_nettype none
module unicode_transcoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            src_valid,
	output logic                                 src_ready,
	input  wire ut_pkg::ut_src_t                 src_word,
	output logic                                 dst_valid,
	input  wire logic                            dst_ready,
	output ut_pkg::ut_dst_t                      dst_word,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ut_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [1:0]                      cfg_data
);
	import ut_pkg::*;

	logic [1:0] src_enc_q;
	logic [1:0] tgt_enc_q;
	logic       cfg_clear;
	logic       q_full;
	logic       push;
	ut_entry_t  push_data;
	logic       head_valid;
	ut_entry_t  head;
	logic       pop;

	assign cfg_ready = 1'b1;
	assign cfg_clear = cfg_valid && cfg_ready
		&& ((cfg_index == REG_SOURCE) || (cfg_index == REG_TARGET));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_enc_q <= ENC_BYTE;
			tgt_enc_q <= ENC_BYTE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE: src_enc_q <= cfg_data;
				REG_TARGET: tgt_enc_q <= cfg_data;
				default:    src_enc_q <= src_enc_q;
			endcase
		end
	end

	ut_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_word  (src_word),
		.src_enc   (src_enc_q),
		.tgt_enc   (tgt_enc_q),
		.cfg_clear (cfg_clear),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	ut_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	ut_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.tgt_enc    (tgt_enc_q),
		.dst_valid  (dst_valid),
		.dst_ready  (dst_ready),
		.dst_word   (dst_word)
	);

endmodule
`default_nettype wire

// File: rtl/ut_queue.sv
// Short queue of decoded code points between the front and back ends.
// Depends on ut_pkg for the entry type and depth.
`default_nettype none
`include "unicode_transcoder_macros.svh"
module ut_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ut_pkg::ut_entry_t push_data,
	output logic                   full,
	output logic                   head_valid,
	output ut_pkg::ut_entry_t      head,
	input  wire logic              pop
);
	import ut_pkg::*;

	ut_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QCNT_W-1:0]  cnt_q;

	assign full       = (cnt_q == QCNT_W'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`UT_NEVER(q_push_when_full, push && full && !pop, "word pushed into a full queue")
	`UT_NEVER(q_pop_when_empty, pop && !head_valid, "word popped from an empty queue")
	`UT_ASSERT(q_count_bound, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

// File: rtl/ut_front.sv
// Front end: accepts source units, gathers multi-unit sequences into code points.
// Depends on ut_pkg; feeds ut_queue.
`default_nettype none
`include "unicode_transcoder_macros.svh"
module ut_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              src_valid,
	output logic                   src_ready,
	input  wire ut_pkg::ut_src_t   src_word,
	input  wire logic [1:0]        src_enc,
	input  wire logic [1:0]        tgt_enc,
	input  wire logic              cfg_clear,
	input  wire logic              q_full,
	output logic                   push,
	output ut_pkg::ut_entry_t      push_data
);
	import ut_pkg::*;

	logic [20:0] partial_q;
	logic [1:0]  left_q;
	logic [20:0] partial_d;
	logic [1:0]  left_d;
	logic [31:0] code;
	logic        done;
	logic        same;
	logic        accept;
	logic [7:0]  b;
	logic [15:0] w;
	logic [20:0] shifted;

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;
	assign same      = (src_enc == tgt_enc);
	assign b         = src_word.in_unit[7:0];
	assign w         = src_word.in_unit[15:0];
	assign shifted   = {partial_q[14:0], b[5:0]};

	always_comb begin
		partial_d = partial_q;
		left_d    = left_q;
		code      = '0;
		done      = 1'b0;
		unique case (src_enc)
			ENC_BYTE: begin
				code = {24'd0, b};
				done = 1'b1;
			end
			ENC_UTF8: begin
				if (left_q != 2'd0) begin
					partial_d = shifted;
					left_d    = left_q - 1'b1;
					if (left_q == 2'd1) begin
						code      = {11'd0, shifted};
						partial_d = '0;
						done      = 1'b1;
					end
				end else if (!b[7]) begin
					code = {24'd0, b};
					done = 1'b1;
				end else if (b[5]) begin
					if (b[4]) begin
						partial_d = {18'd0, b[2:0]};
						left_d    = 2'd3;
					end else begin
						partial_d = {17'd0, b[3:0]};
						left_d    = 2'd2;
					end
				end else begin
					partial_d = {16'd0, b[4:0]};
					left_d    = 2'd1;
				end
			end
			ENC_UTF16: begin
				if (left_q != 2'd0) begin
					code      = 32'({partial_q[9:0], w[9:0]}) + 32'h0001_0000;
					partial_d = '0;
					left_d    = 2'd0;
					done      = 1'b1;
				end else if (w[15:10] == 6'b110110) begin
					partial_d = {11'd0, w[9:0]};
					left_d    = 2'd1;
				end else begin
					code = {16'd0, w};
					done = 1'b1;
				end
			end
			ENC_UTF32: begin
				code = src_word.in_unit;
				done = 1'b1;
			end
			default: begin
				code = '0;
				done = 1'b0;
			end
		endcase
		if (src_word.text_end) begin
			partial_d = '0;
			left_d    = 2'd0;
		end
	end

	always_comb begin
		push_data.text_end = src_word.text_end;
		push_data.copy     = same;
		if (same) begin
			case (src_enc)
				ENC_UTF32: push_data.code = src_word.in_unit;
				ENC_UTF16: push_data.code = {16'd0, w};
				default:   push_data.code = {24'd0, b};
			endcase
		end else begin
			push_data.code = code;
		end
	end

	assign push = accept && (same || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			left_q    <= '0;
		end else if (cfg_clear) begin
			partial_q <= '0;
			left_q    <= '0;
		end else if (accept && !same) begin
			partial_q <= partial_d;
			left_q    <= left_d;
		end
	end

	`UT_ASSERT(fe_pending_utf8_only, src_enc != ENC_UTF8 |-> left_q <= 2'd1,
		"multi-unit count pending outside UTF-8 decoding")
	`UT_ASSERT(fe_end_clears, accept && src_word.text_end && !cfg_clear |=> left_q == 2'd0,
		"pending sequence survived the end of the text")

endmodule
`default_nettype wire

// File: rtl/ut_back.sv
// Back end: encodes queued code points; sends one target unit per cycle
// while dst is not stalled. Depends on ut_pkg; drains ut_queue.
`default_nettype none
`include "unicode_transcoder_macros.svh"
module ut_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire ut_pkg::ut_entry_t head,
	output logic                   pop,
	input  wire logic [1:0]        tgt_enc,
	output logic                   dst_valid,
	input  wire logic              dst_ready,
	output ut_pkg::ut_dst_t        dst_word
);
	import ut_pkg::*;

	logic [31:0] u [4];
	logic [1:0]  last_idx;
	logic [1:0]  k_q;
	logic        emit;
	logic        at_last;
	logic [31:0] s;
	logic [31:0] c;
	logic        out_valid_q;
	ut_dst_t     out_q;

	assign c = head.code;
	assign s = c - 32'h0001_0000;

	always_comb begin
		u[0]     = c;
		u[1]     = '0;
		u[2]     = '0;
		u[3]     = '0;
		last_idx = 2'd0;
		if (head.copy) begin
			u[0] = c;
		end else begin
			unique case (tgt_enc)
				ENC_BYTE: u[0] = {24'd0, c[7:0]};
				ENC_UTF8: begin
					if (c[31:16] != '0) begin
						u[0]     = {24'd0, 5'b11110, c[20:18]};
						u[1]     = {24'd0, 2'b10, c[17:12]};
						u[2]     = {24'd0, 2'b10, c[11:6]};
						u[3]     = {24'd0, 2'b10, c[5:0]};
						last_idx = 2'd3;
					end else if (c[15:11] != '0) begin
						u[0]     = {24'd0, 4'b1110, c[15:12]};
						u[1]     = {24'd0, 2'b10, c[11:6]};
						u[2]     = {24'd0, 2'b10, c[5:0]};
						last_idx = 2'd2;
					end else if (c[10:7] != '0) begin
						u[0]     = {24'd0, 3'b110, c[10:6]};
						u[1]     = {24'd0, 2'b10, c[5:0]};
						last_idx = 2'd1;
					end
				end
				ENC_UTF16: begin
					if (c[31:16] != '0) begin
						u[0]     = {16'd0, 6'b110110, s[19:10]};
						u[1]     = {16'd0, 6'b110111, s[9:0]};
						last_idx = 2'd1;
					end
				end
				ENC_UTF32: u[0] = c;
				default:   u[0] = c;
			endcase
		end
	end

	assign emit    = head_valid && (!out_valid_q || dst_ready);
	assign at_last = (k_q == last_idx);
	assign pop     = emit && at_last;

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= {u[k_q], at_last, at_last && head.text_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				k_q <= at_last ? 2'd0 : k_q + 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (dst_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign dst_valid = out_valid_q;
	assign dst_word  = out_q;

	`UT_ASSERT(be_index_bound, head_valid |-> k_q <= last_idx,
		"unit index ran past the end of the run")
	`UT_ASSERT(be_idle_index, !head_valid |-> k_q == 2'd0,
		"unit index left mid-run with nothing queued")
	`UT_ASSERT(be_text_on_last, out_valid_q && !out_q.run_last |-> !out_q.text_last,
		"end of text marked on a word that does not close its run")

endmodule
`default_nettype wire

// File: tb/sv/unicode_transcoder_test.sv
// Self-checking testbench for the Unicode transcoder: directed and random source words
// with their expected target words predicted in step. Depends on ut_pkg and unicode_transcoder.
`default_nettype none
module unicode_transcoder_test;
	import ut_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 150;
	localparam int PHASES        = 10;
	localparam int PHASE_WORDS   = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	ut_src_t src_word = '0;
	logic dst_valid;
	logic dst_ready = 1'b0;
	ut_dst_t dst_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [1:0] cfg_data = '0;

	logic [1:0] src_enc = ENC_BYTE;
	logic [1:0] dst_enc = ENC_BYTE;
	logic [20:0] seq_code = '0;
	logic [1:0] seq_left = '0;
	ut_dst_t awaited_units[$];

	int errors = 0;
	int words_sent = 0;
	int units_checked = 0;
	int reg_writes = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_request = 0;
	int stall_left = 0;

	always #5 clk = ~clk;

	unicode_transcoder DUT (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_ready(src_ready), .src_word(src_word),
		.dst_valid(dst_valid), .dst_ready(dst_ready), .dst_word(dst_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 70) return $urandom_range(2, 0);
		if (r < 94) return $urandom_range(6, 3);
		return $urandom_range(30, 10);
	endfunction

	// Splits a code value into the units of the given encoding; returns how many.
	function automatic int encode_point(input logic [31:0] c, input logic [1:0] enc,
			output logic [3:0][31:0] u);
		logic [31:0] s;
		u = '0;
		s = c - 32'h10000;
		case (enc)
			ENC_BYTE: begin
				u[0] = {24'b0, c[7:0]};
				return 1;
			end
			ENC_UTF8: begin
				if (c > 32'hFFFF) begin
					u[0] = 32'hF0 | {29'b0, c[20:18]};
					u[1] = 32'h80 | {26'b0, c[17:12]};
					u[2] = 32'h80 | {26'b0, c[11:6]};
					u[3] = 32'h80 | {26'b0, c[5:0]};
					return 4;
				end else if (c > 32'h7FF) begin
					u[0] = 32'hE0 | {28'b0, c[15:12]};
					u[1] = 32'h80 | {26'b0, c[11:6]};
					u[2] = 32'h80 | {26'b0, c[5:0]};
					return 3;
				end else if (c > 32'h7F) begin
					u[0] = 32'hC0 | {27'b0, c[10:6]};
					u[1] = 32'h80 | {26'b0, c[5:0]};
					return 2;
				end
			end
			ENC_UTF16: begin
				if (c > 32'hFFFF) begin
					u[0] = 32'hD800 | {22'b0, s[19:10]};
					u[1] = 32'hDC00 | {22'b0, s[9:0]};
					return 2;
				end
			end
			default: ;
		endcase
		u[0] = c;
		return 1;
	endfunction

	function automatic void transcode_item(input ut_src_t it);
		logic [31:0] code;
		logic [7:0] b;
		logic [15:0] w;
		logic [3:0][31:0] u;
		logic done;
		int n;
		ut_dst_t r;
		code = '0;
		done = 1'b0;
		n = 0;
		u = '0;
		b = it.in_unit[7:0];
		w = it.in_unit[15:0];
		if (src_enc == dst_enc) begin
			n = 1;
			case (src_enc)
				ENC_UTF32: u[0] = it.in_unit;
				ENC_UTF16: u[0] = {16'b0, w};
				default: u[0] = {24'b0, b};
			endcase
		end else begin
			case (src_enc)
				ENC_BYTE: begin
					code = {24'b0, b};
					done = 1'b1;
				end
				ENC_UTF8: begin
					if (seq_left != 0) begin
						seq_code = {seq_code[14:0], b[5:0]};
						seq_left = seq_left - 2'd1;
						if (seq_left == 0) begin
							code = {11'b0, seq_code};
							seq_code = '0;
							done = 1'b1;
						end
					end else if (!b[7]) begin
						code = {24'b0, b};
						done = 1'b1;
					end else if (b[5] && b[4]) begin
						seq_code = {18'b0, b[2:0]};
						seq_left = 2'd3;
					end else if (b[5]) begin
						seq_code = {17'b0, b[3:0]};
						seq_left = 2'd2;
					end else begin
						seq_code = {16'b0, b[4:0]};
						seq_left = 2'd1;
					end
				end
				ENC_UTF16: begin
					if (seq_left != 0) begin
						code = {12'b0, seq_code[9:0], w[9:0]} + 32'h10000;
						seq_code = '0;
						seq_left = '0;
						done = 1'b1;
					end else if (w[15:10] == 6'b110110) begin
						seq_code = {11'b0, w[9:0]};
						seq_left = 2'd1;
					end else begin
						code = {16'b0, w};
						done = 1'b1;
					end
				end
				default: begin
					code = it.in_unit;
					done = 1'b1;
				end
			endcase
			if (done) n = encode_point(code, dst_enc, u);
			if (it.text_end) begin
				seq_code = '0;
				seq_left = '0;
			end
		end
		for (int k = 0; k < n; k++) begin
			r.out_unit = u[k];
			r.run_last = (k == n - 1);
			r.text_last = (k == n - 1) && it.text_end;
			awaited_units.push_back(r);
		end
	endfunction

	function automatic logic [31:0] pick_code();
		case ($urandom_range(4))
			0: return $urandom_range(32'h7F, 0);
			1: return $urandom_range(32'h7FF, 32'h80);
			2: return $urandom_range(32'hFFFF, 32'h800);
			3: return $urandom_range(32'h10FFFF, 32'h10000);
			default: return (src_enc == ENC_UTF32) ? $urandom : $urandom_range(32'h10FFFF, 0);
		endcase
	endfunction

	always @(negedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end
		if (stall_left == 0 && rx_idle_on && $urandom_range(99) < 30) stall_left = pick_gap();
		if (stall_left > 0) begin
			dst_ready <= 1'b0;
			stall_left--;
		end else begin
			dst_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		ut_dst_t want;
		if (arst_n && dst_valid && dst_ready) begin
			units_checked++;
			if (awaited_units.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got %h/%b/%b", $time,
					dst_word.out_unit, dst_word.run_last, dst_word.text_last);
			end else begin
				want = awaited_units.pop_front();
				if (dst_word.out_unit !== want.out_unit || dst_word.run_last !== want.run_last
						|| dst_word.text_last !== want.text_last) begin
					errors++;
					$display("%0t: mismatch, expected %h/%b/%b, got %h/%b/%b", $time,
						want.out_unit, want.run_last, want.text_last,
						dst_word.out_unit, dst_word.run_last, dst_word.text_last);
				end
			end
		end
	end

	task automatic send_word(input logic [31:0] unit, input logic last);
		int gap;
		gap = tx_idle_on ? pick_gap() : 0;
		repeat (gap) begin
			@(negedge clk);
			src_valid <= 1'b0;
		end
		@(negedge clk);
		src_word <= {unit, last};
		src_valid <= 1'b1;
		do @(posedge clk); while (!src_ready);
		transcode_item(src_word);
		words_sent++;
	endtask

	// Sends the units of one code point in the current source encoding, with junk in the
	// unused upper bits; a cut sequence stops short of its last unit.
	task automatic send_point(input logic [31:0] cp, input logic last, input bit cut);
		logic [3:0][31:0] u;
		logic [31:0] unit;
		int n;
		n = encode_point(cp, src_enc, u);
		if (cut && n > 1) n = $urandom_range(n - 1, 1);
		for (int k = 0; k < n; k++) begin
			unit = $urandom;
			case (src_enc)
				ENC_UTF32: unit = u[k];
				ENC_UTF16: unit = {unit[31:16], u[k][15:0]};
				default: unit = {unit[31:8], u[k][7:0]};
			endcase
			send_word(unit, last && (k == n - 1));
		end
	endtask

	task automatic settle();
		@(negedge clk);
		src_valid <= 1'b0;
		while (awaited_units.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] data);
		settle();
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_SOURCE) src_enc = data;
		else if (idx == REG_TARGET) dst_enc = data;
		if (idx == REG_SOURCE || idx == REG_TARGET) begin
			seq_code = '0;
			seq_left = '0;
		end
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_codec(input logic [1:0] from_enc, input logic [1:0] to_enc);
		write_reg(REG_SOURCE, from_enc);
		write_reg(REG_TARGET, to_enc);
	endtask

	task automatic test_copy_modes();
		for (int e = 0; e < 4; e++) begin
			set_codec(2'(e), 2'(e));
			send_word(32'hFFFF_FFFF, 1'b1);
			send_word(32'h0000_0000, 1'b0);
		end
	endtask

	task automatic test_utf8_source();
		set_codec(ENC_UTF8, ENC_UTF16);
		send_word(32'hA5A5_A5F7, 1'b0);
		send_word(32'h5A5A_5ABF, 1'b0);
		send_word(32'hFFFF_FFBF, 1'b0);
		send_word(32'h0000_00BF, 1'b1);
		// A continuation byte with nothing pending opens a two-byte sequence.
		send_word(32'h0000_0080, 1'b0);
		send_word(32'h0000_0041, 1'b0);
		// Text end in the middle of a sequence drops it.
		send_word(32'h0000_00E2, 1'b0);
		send_word(32'h0000_0082, 1'b1);
		send_word(32'h0000_0041, 1'b0);
		send_word(32'h0000_00C3, 1'b0);
		write_reg(REG_TARGET, ENC_UTF8);
		send_word(32'h0000_0041, 1'b0);
		send_word(32'h0000_00C3, 1'b0);
		write_reg(REG_SPARE_LOW, ENC_UTF32);
		send_word(32'h0000_00A9, 1'b0);
	endtask

	task automatic test_utf16_source();
		set_codec(ENC_UTF16, ENC_UTF8);
		send_word(32'h0000_D83D, 1'b0);
		send_word(32'hFFFF_DE00, 1'b1);
		send_word(32'h0000_DC00, 1'b0);
		send_word(32'h1234_FFFF, 1'b0);
	endtask

	task automatic test_utf32_source();
		set_codec(ENC_UTF32, ENC_UTF16);
		send_word(32'hFFFF_FFFF, 1'b1);
		write_reg(REG_TARGET, ENC_UTF8);
		send_word(32'hFFFF_FFFF, 1'b0);
		write_reg(REG_TARGET, ENC_BYTE);
		send_word(32'h0000_01FF, 1'b0);
	endtask

	task automatic test_backpressure();
		set_codec(ENC_UTF32, ENC_UTF8);
		tx_idle_on = 1'b0;
		hold_request = LONG_HOLD;
		repeat (24) send_point(pick_code(), $urandom_range(9) == 0, 1'b0);
		settle();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random_text();
		logic [1:0] from_enc;
		logic [1:0] to_enc;
		int target;
		int r;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin from_enc = ENC_BYTE; to_enc = ENC_UTF32; end
				1: begin from_enc = ENC_UTF32; to_enc = ENC_BYTE; end
				2: begin from_enc = ENC_UTF8; to_enc = ENC_UTF16; end
				3: begin from_enc = ENC_UTF16; to_enc = ENC_UTF8; end
				default: begin
					from_enc = 2'($urandom_range(3));
					to_enc = 2'($urandom_range(3));
				end
			endcase
			if ($urandom_range(3) == 0) write_reg(REG_SPARE_HIGH, 2'($urandom_range(3)));
			set_codec(from_enc, to_enc);
			tx_idle_on = ($urandom_range(3) != 0);
			rx_idle_on = ($urandom_range(3) != 0);
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) begin
				r = $urandom_range(99);
				if (r < 12) send_word($urandom, $urandom_range(99) < 6);
				else send_point(pick_code(), $urandom_range(99) < 6, r < 18);
			end
			settle();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_copy_modes();
		test_utf8_source();
		test_utf16_source();
		test_utf32_source();
		test_backpressure();
		test_random_text();
		settle();
		if (awaited_units.size() != 0) begin
			errors++;
			$display("%0t: %0d expected words never arrived", $time, awaited_units.size());
		end
		$display("Sent %0d source words, checked %0d target words, made %0d register writes.",
			words_sent, units_checked, reg_writes);
		$display("Covered copy modes, all decoders, text end, mid-sequence writes and a long stall.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d words still expected.", awaited_units.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
`default_nettype wire
